// File: sv/amed_pkg.sv
// Shared types and constants for the accelerometer motion event detector.
// No dependencies; every other file imports this package.
package amed_pkg;

	localparam int unsigned POLL_MS        = 50;
	localparam int unsigned ONE_G          = 4096;
	localparam int unsigned SHAKE_WINDOW   = 600;
	localparam int unsigned SHAKE_RESET    = 800;
	localparam int unsigned ACT_CAP        = 60000;
	localparam int unsigned WALK_CAP       = 10000;
	localparam int unsigned PICKUP_CD      = 5000;
	localparam int unsigned PUTDOWN_CD     = 3000;
	localparam int unsigned WALK_CD        = 2000;
	localparam int unsigned ELAPSED_MAX    = 65535;
	localparam int unsigned SPIKE_MAX      = 7;
	localparam int unsigned WALK_DEV_LIMIT = (3 * ONE_G + 5) / 10;
	localparam int unsigned DEAD_ZONE      = (15 * ONE_G + 50) / 100;
	localparam int unsigned TILT_FULL      = (80 * ONE_G + 50) / 100;
	localparam int unsigned GAZE_SPAN      = TILT_FULL - DEAD_ZONE;
	localparam int unsigned GAZE_FULL      = 256;

	localparam int unsigned AXIS_W  = 16;
	localparam int unsigned SQ_W    = 2 * AXIS_W - 1;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned MAG_W   = 16;
	localparam int unsigned GAZE_W  = 10;
	localparam int unsigned QUO_W   = $clog2(GAZE_FULL);
	localparam int unsigned SPAN_W  = $clog2(GAZE_SPAN);
	localparam int unsigned CD_W    = 13;
	localparam int unsigned WALK_W  = 14;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned THR_W   = 15;

	// gaze quotient floor(excess * 256 / GAZE_SPAN) as (excess * GAZE_RECIP) >> (RECIP_SH - 8),
	// exact for every excess below GAZE_SPAN
	localparam int unsigned     RECIP_SH   = 32;
	localparam longint unsigned GAZE_RECIP = ((64'd1 << RECIP_SH) + GAZE_SPAN - 1) / GAZE_SPAN;
	localparam int unsigned     RECIP_W    = $clog2(GAZE_RECIP);
	localparam int unsigned     GPROD_W    = SPAN_W + RECIP_W;

	typedef enum logic [2:0] {
		REG_TAP_THRESHOLD,
		REG_SHAKE_THRESHOLD,
		REG_STILL_DEVIATION,
		REG_WALK_STEP_LO,
		REG_WALK_STEP_HI,
		REG_PICKUP_STILL_MS,
		REG_PUTDOWN_ACTIVE_MS,
		REG_WALK_CONFIRM_MS
	} amed_reg_t;

	typedef struct packed {
		logic [THR_W-1:0]  tap_threshold;
		logic [THR_W-1:0]  shake_threshold;
		logic [THR_W-1:0]  still_deviation;
		logic [THR_W-1:0]  walk_step_lo;
		logic [THR_W-1:0]  walk_step_hi;
		logic [TIME_W-1:0] pickup_still_ms;
		logic [TIME_W-1:0] putdown_active_ms;
		logic [WALK_W-1:0] walk_confirm_ms;
	} amed_cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0]         sum_sq;
		logic signed [GAZE_W-1:0] gaze;
	} amed_item_t;

endpackage

// File: sv/amed_front.sv
// Front end: takes a sample transfer, forms x*x + y*y + z*z with one shared
// multiplier and the tilt gaze with a reciprocal multiply. Uses amed_pkg.
module amed_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [47:0]         in_data,
	output logic                push,
	output amed_pkg::amed_item_t push_item,
	input  logic                push_ready
);
	import amed_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_WORK, ST_PUSH} state_t;

	state_t                    state_q;
	logic [2:0]                cnt_q;
	logic signed [AXIS_W-1:0]  ax_q, ay_q, az_q;
	logic [SQ_W-1:0]           prod_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SPAN_W-1:0]         excess_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      neg_q, zero_q, sat_q;

	logic signed [AXIS_W-1:0]  in_x, in_y, in_z, op;
	logic signed [2*AXIS_W-1:0] sq;
	logic [AXIS_W-1:0]         absx, excess;
	logic [GPROD_W-1:0]        gaze_prod;
	logic [GAZE_W-1:0]         gaze_mag;

	assign in_x = in_data[15:0];
	assign in_y = in_data[31:16];
	assign in_z = in_data[47:32];
	assign absx = in_x[AXIS_W-1] ? (~in_x + AXIS_W'(1)) : in_x;
	assign excess = absx - AXIS_W'(DEAD_ZONE);
	assign op = (cnt_q == 3'd0) ? ax_q : ((cnt_q == 3'd1) ? ay_q : az_q);
	assign sq = op * op;
	assign gaze_prod = GPROD_W'(excess_q) * GPROD_W'(GAZE_RECIP);

	assign in_ready = (state_q == ST_IDLE);
	assign push = (state_q == ST_PUSH);

	always_comb begin
		if (zero_q) begin
			gaze_mag = '0;
		end else if (sat_q) begin
			gaze_mag = GAZE_W'(GAZE_FULL);
		end else begin
			gaze_mag = GAZE_W'(quo_q);
		end
		push_item.sum_sq = sum_q;
		push_item.gaze = neg_q ? -$signed(gaze_mag) : $signed(gaze_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WORK;
						cnt_q <= '0;
					end
				end
				ST_WORK: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ax_q <= in_x;
			ay_q <= in_y;
			az_q <= in_z;
			sum_q <= '0;
			neg_q <= in_x[AXIS_W-1];
			zero_q <= (absx <= AXIS_W'(DEAD_ZONE));
			sat_q <= (excess >= AXIS_W'(GAZE_SPAN));
			excess_q <= excess[SPAN_W-1:0];
			quo_q <= '0;
		end else if (state_q == ST_WORK) begin
			prod_q <= sq[SQ_W-1:0];
			if (cnt_q inside {[3'd1:3'd3]}) begin
				sum_q <= sum_q + SUM_W'(prod_q);
			end
			quo_q <= gaze_prod[RECIP_SH-1 -: QUO_W];
		end
	end

endmodule

// File: sv/amed_queue.sv
// Two-entry queue between front and back ends.
// Uses amed_pkg for the item type.
module amed_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  amed_pkg::amed_item_t push_item,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output amed_pkg::amed_item_t pop_item
);
	import amed_pkg::*;

	amed_item_t entry_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = entry_q[rd_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_item;
		end
	end

endmodule

// File: sv/amed_back.sv
// Back end: iterative integer square root, event timers and the output register.
// Uses amed_pkg for the configuration and item types.
module amed_back (
	input  logic                clk,
	input  logic                arst_n,
	input  amed_pkg::amed_cfg_t cfg,
	input  logic                pop_valid,
	input  amed_pkg::amed_item_t pop_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         out_data
);
	import amed_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_ROOT, ST_DIFF, ST_EVAL} state_t;

	state_t                   state_q;
	logic [3:0]               cnt_q;
	logic [SUM_W-1:0]         rad_q;
	logic [MAG_W+2:0]         rem_q;
	logic [MAG_W-1:0]         root_q, prev_q, delta_q, dev_q;
	logic signed [GAZE_W-1:0] gaze_q;
	logic [CNT_W-1:0]         spikes_q;
	logic [TIME_W-1:0]        elapsed_q, still_q, active_q;
	logic                     near_q;
	logic [WALK_W-1:0]        walk_q;
	logic [CD_W-1:0]          pick_cd_q, put_cd_q, walk_cd_q;
	logic                     out_valid_q;
	logic [15:0]              out_data_q;

	logic [MAG_W+2:0]         rem_n, trial;
	logic                     slot_free;

	logic [CNT_W-1:0]         spikes_d;
	logic [TIME_W-1:0]        elapsed_d, still_d, active_d;
	logic                     near_d;
	logic [WALK_W-1:0]        walk_d;
	logic [CD_W-1:0]          pick_cd_d, put_cd_d, walk_cd_d;
	logic                     tap, shake, pickup, putdown, walking;

	assign rem_n = {rem_q[MAG_W:0], rad_q[SUM_W-1:SUM_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign slot_free = !out_valid_q || out_ready;
	assign pop = (state_q == ST_IDLE) && pop_valid;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		logic [CD_W-1:0]   pick_t, put_t, walk_t;
		logic [TIME_W-1:0] elapsed_t, el2;
		logic [CNT_W-1:0]  cnt2;
		logic              near, walk_like;

		pick_t = (pick_cd_q > CD_W'(POLL_MS)) ? pick_cd_q - CD_W'(POLL_MS) : '0;
		put_t = (put_cd_q > CD_W'(POLL_MS)) ? put_cd_q - CD_W'(POLL_MS) : '0;
		walk_t = (walk_cd_q > CD_W'(POLL_MS)) ? walk_cd_q - CD_W'(POLL_MS) : '0;
		elapsed_t = (elapsed_q > TIME_W'(ELAPSED_MAX - POLL_MS)) ?
			TIME_W'(ELAPSED_MAX) : elapsed_q + TIME_W'(POLL_MS);
		el2 = elapsed_t;
		cnt2 = spikes_q;
		near = dev_q < MAG_W'(cfg.still_deviation);
		walk_like = (delta_q >= MAG_W'(cfg.walk_step_lo)) &&
			(delta_q <= MAG_W'(cfg.walk_step_hi)) && (dev_q < MAG_W'(WALK_DEV_LIMIT));

		tap = 1'b0;
		shake = 1'b0;
		pickup = 1'b0;
		putdown = 1'b0;
		walking = 1'b0;
		spikes_d = spikes_q;
		elapsed_d = elapsed_t;
		still_d = still_q;
		active_d = active_q;
		near_d = near_q;
		walk_d = walk_q;
		pick_cd_d = pick_t;
		put_cd_d = put_t;
		walk_cd_d = walk_t;

		if (delta_q > MAG_W'(cfg.tap_threshold) && spikes_q <= CNT_W'(1)) begin
			tap = 1'b1;
			spikes_d = '0;
		end else begin
			if (delta_q > MAG_W'(cfg.shake_threshold)) begin
				if (spikes_q == '0) begin
					el2 = '0;
				end
				if (spikes_q < CNT_W'(SPIKE_MAX)) begin
					cnt2 = spikes_q + CNT_W'(1);
				end
				elapsed_d = el2;
				if (cnt2 >= CNT_W'(3) && el2 < TIME_W'(SHAKE_WINDOW)) begin
					shake = 1'b1;
					spikes_d = '0;
				end else begin
					spikes_d = cnt2;
				end
			end else if (elapsed_t > TIME_W'(SHAKE_RESET)) begin
				spikes_d = '0;
			end

			if (near) begin
				still_d = (still_q < TIME_W'(ACT_CAP)) ? still_q + TIME_W'(POLL_MS) :
					TIME_W'(ACT_CAP);
				active_d = '0;
				if (!near_q && active_q >= cfg.putdown_active_ms && put_t == '0) begin
					putdown = 1'b1;
					put_cd_d = CD_W'(PUTDOWN_CD);
				end
			end else begin
				active_d = (active_q < TIME_W'(ACT_CAP)) ? active_q + TIME_W'(POLL_MS) :
					TIME_W'(ACT_CAP);
				still_d = '0;
				if (near_q && still_q >= cfg.pickup_still_ms && pick_t == '0) begin
					pickup = 1'b1;
					pick_cd_d = CD_W'(PICKUP_CD);
				end
			end
			near_d = near;

			if (walk_like) begin
				walk_d = (walk_q < WALK_W'(WALK_CAP)) ? walk_q + WALK_W'(POLL_MS) :
					WALK_W'(WALK_CAP);
			end else begin
				walk_d = (walk_q > WALK_W'(POLL_MS)) ? walk_q - WALK_W'(POLL_MS) : '0;
			end
			if (walk_d >= cfg.walk_confirm_ms && walk_t == '0) begin
				walking = 1'b1;
				walk_cd_d = CD_W'(WALK_CD);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			prev_q <= MAG_W'(ONE_G);
			spikes_q <= '0;
			elapsed_q <= TIME_W'(ELAPSED_MAX);
			still_q <= '0;
			active_q <= '0;
			near_q <= 1'b0;
			walk_q <= '0;
			pick_cd_q <= '0;
			put_cd_q <= '0;
			walk_cd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EVAL && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_ROOT;
						cnt_q <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					prev_q <= root_q;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (slot_free) begin
						spikes_q <= spikes_d;
						elapsed_q <= elapsed_d;
						still_q <= still_d;
						active_q <= active_d;
						near_q <= near_d;
						walk_q <= walk_d;
						pick_cd_q <= pick_cd_d;
						put_cd_q <= put_cd_d;
						walk_cd_q <= walk_cd_d;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rad_q <= pop_item.sum_sq;
				gaze_q <= pop_item.gaze;
				rem_q <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q <= {rad_q[SUM_W-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q <= rem_n - trial;
					root_q <= {root_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					root_q <= {root_q[MAG_W-2:0], 1'b0};
				end
			end
			ST_DIFF: begin
				delta_q <= (root_q > prev_q) ? root_q - prev_q : prev_q - root_q;
				dev_q <= (root_q > MAG_W'(ONE_G)) ? root_q - MAG_W'(ONE_G) :
					MAG_W'(ONE_G) - root_q;
			end
			ST_EVAL: begin
				if (slot_free) begin
					out_data_q <= {1'b0, gaze_q, walking, putdown, pickup, shake, tap};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_tap_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[0] |-> out_data_q[4:1] == 4'b0000)
		else $error("tap reported together with another event");
	a_pick_put: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[2] && out_data_q[3]))
		else $error("pickup and putdown in one result");
	a_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		pick_cd_q <= CD_W'(PICKUP_CD) && put_cd_q <= CD_W'(PUTDOWN_CD) &&
		walk_cd_q <= CD_W'(WALK_CD))
		else $error("cooldown above its load value");
	a_eval_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL && !slot_free |=> state_q == ST_EVAL)
		else $error("result dropped while output register full");
`endif

endmodule

// File: sv/accel_motion_event_detector.sv
// Top level of the accelerometer motion event detector: configuration
// registers and the front end, queue and back end. Uses amed_pkg.
//
// channel  | dir | handshake                     | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: accel_x, accel_y, accel_z
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: events, gaze_horizontal
// cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// The front end loads a sample, runs 8 work steps and pushes the result; the
// back end picks up an item and runs 16 square-root steps, difference and
// evaluate; it sets the sustained rate. Neither end takes a new sample before
// it is done with the last. Reset restores all timers, the configuration and
// the control state but not datapath registers; a full output register stalls
// the back end, and the two-entry queue lets the front accept until it fills.
module accel_motion_event_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // tap_event, shake_event, pickup_event,
	                                    // putdown_event, walking_event,
	                                    // gaze_horizontal, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import amed_pkg::*;

	amed_cfg_t  cfg_q;
	amed_item_t push_item, pop_item;
	logic       push, push_ready, pop, pop_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_threshold <= THR_W'(2662);
			cfg_q.shake_threshold <= THR_W'(2048);
			cfg_q.still_deviation <= THR_W'(410);
			cfg_q.walk_step_lo <= THR_W'(205);
			cfg_q.walk_step_hi <= THR_W'(1556);
			cfg_q.pickup_still_ms <= TIME_W'(3000);
			cfg_q.putdown_active_ms <= TIME_W'(1500);
			cfg_q.walk_confirm_ms <= WALK_W'(600);
		end else if (cfg_valid) begin
			case (amed_reg_t'(cfg_index))
				REG_TAP_THRESHOLD:     cfg_q.tap_threshold <= cfg_data[THR_W-1:0];
				REG_SHAKE_THRESHOLD:   cfg_q.shake_threshold <= cfg_data[THR_W-1:0];
				REG_STILL_DEVIATION:   cfg_q.still_deviation <= cfg_data[THR_W-1:0];
				REG_WALK_STEP_LO:      cfg_q.walk_step_lo <= cfg_data[THR_W-1:0];
				REG_WALK_STEP_HI:      cfg_q.walk_step_hi <= cfg_data[THR_W-1:0];
				REG_PICKUP_STILL_MS:   cfg_q.pickup_still_ms <= cfg_data[TIME_W-1:0];
				REG_PUTDOWN_ACTIVE_MS: cfg_q.putdown_active_ms <= cfg_data[TIME_W-1:0];
				REG_WALK_CONFIRM_MS:   cfg_q.walk_confirm_ms <= cfg_data[WALK_W-1:0];
				default: ;
			endcase
		end
	end

	amed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	amed_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	amed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule

// File: verif/tb_accel_motion_event_detector.sv
// Self-checking testbench for accel_motion_event_detector: streams accelerometer samples,
// predicts every event and gaze result in step with the stream and checks it. Needs amed_pkg.
`timescale 1ns / 100ps

module tb_accel_motion_event_detector;
	import amed_pkg::*;

	localparam int unsigned SHAKE_SPIKES = 3;
	localparam int          RANDOM_ITEMS = 1300;
	localparam int          END_CYCLES   = 60;

	// m_axis_tdata layout, lowest bit first: tap, shake, pickup, putdown, walking, gaze, pad
	typedef struct packed {
		logic                     pad;
		logic signed [GAZE_W-1:0] gaze;
		logic                     walking;
		logic                     putdown;
		logic                     pickup;
		logic                     shake;
		logic                     tap;
	} motion_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	accel_motion_event_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	motion_result_t expected_motion[$];
	int             mismatch_count = 0;
	int             samples_sent = 0;
	bit             idle_on = 1'b1;
	int             sink_hold = 0;

	// predictor state and register copy
	int unsigned det_cfg[8];
	bit [15:0]   cfg_plan[8];
	int unsigned last_mag, spike_count, shake_ms, still_ms, active_ms, walk_ms;
	int unsigned pickup_cd, putdown_cd, walk_cd;
	bit          was_near;

	function automatic int unsigned count_down(input int unsigned v);
		return (v > POLL_MS) ? v - POLL_MS : 0;
	endfunction

	function automatic int unsigned count_up(input int unsigned v, input int unsigned cap);
		return (v < cap) ? v + POLL_MS : cap;
	endfunction

	function automatic int unsigned root_floor(input longint unsigned v);
		longint unsigned r, trial;
		r = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return int'(r);
	endfunction

	function automatic int unsigned cfg_mask(input amed_reg_t r);
		case (r)
			REG_PICKUP_STILL_MS, REG_PUTDOWN_ACTIVE_MS: return (1 << TIME_W) - 1;
			REG_WALK_CONFIRM_MS: return (1 << WALK_W) - 1;
			default: return (1 << THR_W) - 1;
		endcase
	endfunction

	function automatic void plan_defaults();
		cfg_plan[REG_TAP_THRESHOLD]     = 2662;
		cfg_plan[REG_SHAKE_THRESHOLD]   = 2048;
		cfg_plan[REG_STILL_DEVIATION]   = 410;
		cfg_plan[REG_WALK_STEP_LO]      = 205;
		cfg_plan[REG_WALK_STEP_HI]      = 1556;
		cfg_plan[REG_PICKUP_STILL_MS]   = 3000;
		cfg_plan[REG_PUTDOWN_ACTIVE_MS] = 1500;
		cfg_plan[REG_WALK_CONFIRM_MS]   = 600;
	endfunction

	function automatic void reset_tracker();
		plan_defaults();
		for (int i = 0; i < 8; i++)
			det_cfg[i] = cfg_plan[i];
		last_mag    = ONE_G;
		spike_count = 0;
		shake_ms    = ELAPSED_MAX;
		still_ms    = 0;
		active_ms   = 0;
		walk_ms     = 0;
		pickup_cd   = 0;
		putdown_cd  = 0;
		walk_cd     = 0;
		was_near    = 1'b0;
	endfunction

	function automatic motion_result_t predict_motion(input logic [47:0] d);
		motion_result_t   res;
		int               ax, ay, az, absx;
		longint unsigned  sum;
		int unsigned      mag, delta, dev, old_still, old_active, q;
		bit               near, walk_like;
		res  = '0;
		ax   = $signed(d[15:0]);
		ay   = $signed(d[31:16]);
		az   = $signed(d[47:32]);
		pickup_cd  = count_down(pickup_cd);
		putdown_cd = count_down(putdown_cd);
		walk_cd    = count_down(walk_cd);
		shake_ms   = (shake_ms + POLL_MS > ELAPSED_MAX) ? ELAPSED_MAX : shake_ms + POLL_MS;

		sum   = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
		mag   = root_floor(sum) & 16'hFFFF;
		delta = (mag > last_mag) ? mag - last_mag : last_mag - mag;
		dev   = (mag > ONE_G) ? mag - ONE_G : ONE_G - mag;
		last_mag = mag;

		if (delta > det_cfg[REG_TAP_THRESHOLD] && spike_count <= 1) begin
			res.tap = 1'b1;
			spike_count = 0;
		end else begin
			old_still  = still_ms;
			old_active = active_ms;
			if (delta > det_cfg[REG_SHAKE_THRESHOLD]) begin
				if (spike_count == 0)
					shake_ms = 0;
				if (spike_count < SPIKE_MAX)
					spike_count++;
				if (spike_count >= SHAKE_SPIKES && shake_ms < SHAKE_WINDOW) begin
					res.shake = 1'b1;
					spike_count = 0;
				end
			end else if (shake_ms > SHAKE_RESET) begin
				spike_count = 0;
			end

			near = dev < det_cfg[REG_STILL_DEVIATION];
			if (near) begin
				still_ms  = count_up(still_ms, ACT_CAP);
				active_ms = 0;
				if (!was_near && old_active >= det_cfg[REG_PUTDOWN_ACTIVE_MS] && putdown_cd == 0) begin
					res.putdown = 1'b1;
					putdown_cd = PUTDOWN_CD;
				end
			end else begin
				active_ms = count_up(active_ms, ACT_CAP);
				still_ms  = 0;
				if (was_near && old_still >= det_cfg[REG_PICKUP_STILL_MS] && pickup_cd == 0) begin
					res.pickup = 1'b1;
					pickup_cd = PICKUP_CD;
				end
			end
			was_near = near;

			walk_like = delta >= det_cfg[REG_WALK_STEP_LO] &&
				delta <= det_cfg[REG_WALK_STEP_HI] && dev < WALK_DEV_LIMIT;
			walk_ms = walk_like ? count_up(walk_ms, WALK_CAP) : count_down(walk_ms);
			if (walk_ms >= det_cfg[REG_WALK_CONFIRM_MS] && walk_cd == 0) begin
				res.walking = 1'b1;
				walk_cd = WALK_CD;
			end
		end

		absx = (ax < 0) ? -ax : ax;
		if (absx > DEAD_ZONE) begin
			q = ((absx - DEAD_ZONE) * GAZE_FULL) / GAZE_SPAN;
			if (q > GAZE_FULL)
				q = GAZE_FULL;
			res.gaze = GAZE_W'((ax < 0) ? -int'(q) : int'(q));
		end
		return res;
	endfunction

	// sink side: random stall bursts
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold     <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			sink_hold     <= $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic compare_field(input string name, input logic signed [10:0] want,
		input logic signed [10:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		motion_result_t seen, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = m_axis_tdata;
			if (expected_motion.size() == 0) begin
				$error("result transfer with no sample pending: tdata %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_motion.pop_front();
				compare_field("tap_event", want.tap, seen.tap);
				compare_field("shake_event", want.shake, seen.shake);
				compare_field("pickup_event", want.pickup, seen.pickup);
				compare_field("putdown_event", want.putdown, seen.putdown);
				compare_field("walking_event", want.walking, seen.walking);
				compare_field("gaze_horizontal", want.gaze, seen.gaze);
			end
		end
	end

	// called at a rising edge; returns at the edge of the transfer with tvalid still high
	task automatic send_sample(input logic [47:0] d);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		expected_motion.push_back(predict_motion(d));
		samples_sent++;
	endtask

	task automatic send_xyz(input int x, input int y, input int z);
		send_sample({z[15:0], y[15:0], x[15:0]});
	endtask

	function automatic int rand_sign(input int v);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	// sample of roughly the given magnitude with tilt x
	function automatic logic [47:0] shape_sample(input int mag, input int x);
		longint rest;
		int     y, z;
		if (mag > 32767)
			mag = 32767;
		if (mag < 0)
			mag = 0;
		if (x > mag)
			x = mag;
		if (x < -mag)
			x = -mag;
		rest = longint'(mag) * mag - longint'(x) * x;
		y = $urandom_range(0, 300);
		if (longint'(y) * y > rest)
			y = 0;
		rest -= longint'(y) * y;
		z = rand_sign(root_floor(rest));
		y = rand_sign(y);
		return {z[15:0], y[15:0], x[15:0]};
	endfunction

	task automatic send_mag(input int mag);
		int span;
		span = (mag < 4200) ? mag : 4200;
		if (span < 0)
			span = 0;
		send_sample(shape_sample(mag, $urandom_range(0, 2 * span) - span));
	endtask

	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_motion.size() != 0) @(posedge clk);
	endtask

	task automatic write_config();
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= amed_reg_t'(i);
			cfg_data  <= cfg_plan[i];
			do @(posedge clk); while (!cfg_ready);
			det_cfg[i] = cfg_plan[i] & cfg_mask(amed_reg_t'(i));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_axis_extremes();
		send_xyz(32767, 32767, 32767);
		send_xyz(-32768, -32768, -32768);
		send_xyz(0, 0, 0);
	endtask

	task automatic test_gaze_edges();
		send_xyz(DEAD_ZONE, 0, ONE_G);
		send_xyz(-(DEAD_ZONE + 1), 0, ONE_G);
		send_xyz(TILT_FULL, 0, ONE_G);
		send_xyz(-(TILT_FULL + 1), 0, ONE_G);
		send_xyz(TILT_FULL + 13, 0, ONE_G);
	endtask

	// one tap up, one tap down, then three mid spikes that make a shake
	task automatic test_tap_and_shake();
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G + 3000);
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G + 2304);
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G + 2304);
	endtask

	task automatic test_register_extremes();
		settle_block();
		cfg_plan = '{default: 16'h0000};
		write_config();
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G + 100);
		settle_block();
		cfg_plan = '{default: 16'hFFFF};
		write_config();
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, 32767);
		send_xyz(0, 0, ONE_G);
		settle_block();
		plan_defaults();
		cfg_plan[REG_PICKUP_STILL_MS]   = 0;
		cfg_plan[REG_PUTDOWN_ACTIVE_MS] = 0;
		write_config();
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G + 1000);
		send_xyz(0, 0, ONE_G);
		send_xyz(0, 0, ONE_G + 1000);
	endtask

	task automatic run_motion_segments(input int count);
		int stop_at, len, base, hi;
		stop_at = samples_sent + count;
		while (samples_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					len = $urandom_range(10, 90);
					repeat (len) send_mag(ONE_G + $urandom_range(0, 400) - 200);
				end
				2, 3: begin
					base = ONE_G + rand_sign($urandom_range(600, 2500));
					len  = $urandom_range(5, 45);
					repeat (len) send_mag(base + $urandom_range(0, 200) - 100);
				end
				4, 5: begin
					len = $urandom_range(4, 16);
					repeat (len) begin
						send_mag(ONE_G + $urandom_range(100, 700));
						send_mag(ONE_G - $urandom_range(100, 700));
					end
				end
				6: begin
					len = $urandom_range(2, 4);
					hi  = ONE_G + $urandom_range(2100, 2600);
					repeat (len) begin
						send_mag(ONE_G);
						send_mag(hi);
					end
				end
				7: begin
					send_mag(ONE_G + $urandom_range(2800, 9000));
					send_mag(ONE_G);
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_sample(48'({$urandom(), $urandom()}));
				end
			endcase
		end
	endtask

	task automatic test_random_motion();
		int phase_items;
		phase_items = RANDOM_ITEMS / 4;

		settle_block();
		plan_defaults();
		write_config();
		run_motion_segments(phase_items);

		settle_block();
		cfg_plan[REG_TAP_THRESHOLD]     = 16'($urandom_range(1500, 4000));
		cfg_plan[REG_SHAKE_THRESHOLD]   = 16'($urandom_range(1000, 2600));
		cfg_plan[REG_STILL_DEVIATION]   = 16'($urandom_range(100, 800));
		cfg_plan[REG_WALK_STEP_LO]      = 16'($urandom_range(0, 400));
		cfg_plan[REG_WALK_STEP_HI]      = 16'($urandom_range(800, 3000));
		cfg_plan[REG_PICKUP_STILL_MS]   = 16'($urandom_range(0, 2000));
		cfg_plan[REG_PUTDOWN_ACTIVE_MS] = 16'($urandom_range(0, 2000));
		cfg_plan[REG_WALK_CONFIRM_MS]   = 16'($urandom_range(0, 1200));
		write_config();
		run_motion_segments(phase_items);

		// raw 16-bit writes, including values past the width of the narrower registers
		settle_block();
		for (int i = 0; i < 8; i++)
			cfg_plan[i] = 16'($urandom_range(0, 16'hFFFF));
		write_config();
		run_motion_segments(phase_items);

		settle_block();
		idle_on = 1'b0;
		plan_defaults();
		write_config();
		run_motion_segments(phase_items);
	endtask

	initial begin
		reset_tracker();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_axis_extremes();
		test_gaze_edges();
		test_tap_and_shake();
		test_register_extremes();
		test_random_motion();
		settle_block();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
